[sv/sfm_pkg.sv]
`timescale 1ns / 1ps

package sfm_pkg;

    localparam int VOLUME_FRAC_BITS_DEF = 24;

    localparam int LEVEL_W     = 7;
    localparam int SAMPLE_W    = 16;
    localparam int FRAMES_W    = 16;
    localparam int STEP_SHIFT  = 5;
    localparam int STEPS_W     = FRAMES_W + STEP_SHIFT;
    localparam int GAIN_W      = 16;
    localparam int GAIN_SHIFT  = 15;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = 7'h7f;
    localparam logic [FRAMES_W-1:0] FADE_FRAMES_MAX = 16'd60000;
    localparam logic signed [SAMPLE_W-1:0] S16_LO   = -16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] S16_HI   = 16'sh7fff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic out_write;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_stat;

    localparam logic [GAIN_W-1:0] GAIN_CURVE [128] = '{
        16'd0,     16'd2,     16'd8,     16'd18,    16'd32,    16'd50,    16'd73,    16'd99,
        16'd130,   16'd164,   16'd203,   16'd245,   16'd292,   16'd343,   16'd398,   16'd457,
        16'd520,   16'd587,   16'd658,   16'd733,   16'd812,   16'd895,   16'd983,   16'd1074,
        16'd1170,  16'd1269,  16'd1373,  16'd1481,  16'd1592,  16'd1708,  16'd1828,  16'd1952,
        16'd2080,  16'd2212,  16'd2348,  16'd2488,  16'd2632,  16'd2781,  16'd2933,  16'd3090,
        16'd3250,  16'd3415,  16'd3583,  16'd3756,  16'd3933,  16'd4114,  16'd4298,  16'd4487,
        16'd4680,  16'd4877,  16'd5079,  16'd5284,  16'd5493,  16'd5706,  16'd5924,  16'd6145,
        16'd6371,  16'd6600,  16'd6834,  16'd7072,  16'd7313,  16'd7559,  16'd7809,  16'd8063,
        16'd8321,  16'd8583,  16'd8849,  16'd9119,  16'd9394,  16'd9672,  16'd9954,  16'd10241,
        16'd10531, 16'd10826, 16'd11125, 16'd11427, 16'd11734, 16'd12045, 16'd12360, 16'd12679,
        16'd13002, 16'd13329, 16'd13660, 16'd13995, 16'd14335, 16'd14678, 16'd15025, 16'd15377,
        16'd15732, 16'd16092, 16'd16456, 16'd16823, 16'd17195, 16'd17571, 16'd17951, 16'd18335,
        16'd18723, 16'd19115, 16'd19511, 16'd19911, 16'd20316, 16'd20724, 16'd21136, 16'd21553,
        16'd21974, 16'd22398, 16'd22827, 16'd23260, 16'd23696, 16'd24137, 16'd24582, 16'd25031,
        16'd25484, 16'd25941, 16'd26402, 16'd26868, 16'd27337, 16'd27810, 16'd28288, 16'd28769,
        16'd29255, 16'd29744, 16'd30238, 16'd30736, 16'd31238, 16'd31744, 16'd32254, 16'd32768
    };

    function automatic logic [GAIN_W-1:0] sfm_gain(input logic [LEVEL_W-1:0] idx);
        return GAIN_CURVE[idx];
    endfunction

endpackage

[sv/sfm_div.sv]
`timescale 1ns / 1ps

module sfm_div import sfm_pkg::*; #(
    parameter int NUM_W = VOLUME_FRAC_BITS_DEF + 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_dividend,
    input  logic [STEPS_W-1:0] i_divisor,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEPS_W-1:0] r_div;
    logic [STEPS_W-1:0] r_rem;
    logic [NUM_W-1:0]   r_quo;

    logic [STEPS_W:0]   rem_sh;
    logic [STEPS_W:0]   diff;

    // One quotient bit per cycle, most significant first.
    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        diff   = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!diff[STEPS_W]) begin
                r_rem <= diff[STEPS_W-1:0];
            end else begin
                r_rem <= rem_sh[STEPS_W-1:0];
            end
            r_quo <= {r_quo[NUM_W-2:0], ~diff[STEPS_W]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[sv/sfm_dp.sv]
`timescale 1ns / 1ps

module sfm_dp import sfm_pkg::*; #(
    parameter int VOLUME_FRAC_BITS = VOLUME_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic                       i_func,
    input  logic                       i_player_open,
    input  logic                       i_has_audio,
    input  logic                       i_playing,
    input  logic                       i_have_source,
    input  logic signed [SAMPLE_W-1:0] i_src_left,
    input  logic signed [SAMPLE_W-1:0] i_src_right,
    input  logic                       i_decoded_valid,
    input  logic signed [SAMPLE_W-1:0] i_decoded_left,
    input  logic signed [SAMPLE_W-1:0] i_decoded_right,
    input  logic signed [SAMPLE_W-1:0] i_fade_volume,
    input  logic [FRAMES_W-1:0]        i_fade_frames,
    output logic signed [SAMPLE_W-1:0] o_out_left,
    output logic signed [SAMPLE_W-1:0] o_out_right,
    output logic                       o_sample_consumed,
    output logic                       o_fade_accepted
);

    // Volume range is +/- 2^(VOLUME_FRAC_BITS+8), so one sign bit and one spare.
    localparam int VOL_W  = VOLUME_FRAC_BITS + 10;
    localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;
    localparam int SCL_W  = PROD_W - GAIN_SHIFT;
    localparam int MIX_W  = SCL_W + 1;
    localparam logic signed [VOL_W:0] SUM_HI = (VOL_W + 1)'(64'sd1 <<< (VOLUME_FRAC_BITS + 8));
    localparam logic signed [VOL_W:0] SUM_LO = -SUM_HI;

    logic signed [VOL_W-1:0]    r_cur;
    logic signed [VOL_W-1:0]    r_step;
    logic [LEVEL_W-1:0]         r_target;
    logic [STEPS_W-1:0]         r_steps;
    logic                       r_neg;

    logic                       r_func;
    logic                       r_act;
    logic                       r_acc;
    logic signed [SAMPLE_W-1:0] r_base_l;
    logic signed [SAMPLE_W-1:0] r_base_r;
    logic signed [SAMPLE_W-1:0] r_dec_l;
    logic signed [SAMPLE_W-1:0] r_dec_r;

    logic [LEVEL_W-1:0]         tgt_cl;
    logic [FRAMES_W-1:0]        frm_cl;
    logic                       fade_ok;
    logic                       active;
    logic signed [VOL_W-1:0]    tgt_fix;
    logic signed [VOL_W-1:0]    cur_fix;
    logic signed [VOL_W:0]      num;
    logic [VOL_W-1:0]           num_mag;
    logic signed [VOL_W:0]      vsum;
    logic signed [VOL_W-1:0]    vsat;
    logic                       div_done;
    logic [VOL_W-1:0]           div_quot;

    logic signed [VOL_W-VOLUME_FRAC_BITS-1:0] ipart;
    logic [LEVEL_W-1:0]         idx;
    logic [GAIN_W-1:0]          gain;
    logic signed [PROD_W-1:0]   prod_l;
    logic signed [PROD_W-1:0]   prod_r;
    logic signed [MIX_W-1:0]    mix_l;
    logic signed [MIX_W-1:0]    mix_r;
    logic signed [SAMPLE_W-1:0] sat_l;
    logic signed [SAMPLE_W-1:0] sat_r;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [MIX_W-1:0] v);
        if (v < MIX_W'(S16_LO)) begin
            return S16_LO;
        end else if (v > MIX_W'(S16_HI)) begin
            return S16_HI;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // Fade command decode from the input beat, and ramp arithmetic on the held volume state.
    always_comb begin
        if (i_fade_volume < 0) begin
            tgt_cl = '0;
        end else if (i_fade_volume > SAMPLE_W'(LEVEL_MAX)) begin
            tgt_cl = LEVEL_MAX;
        end else begin
            tgt_cl = i_fade_volume[LEVEL_W-1:0];
        end
        frm_cl  = (i_fade_frames > FADE_FRAMES_MAX) ? FADE_FRAMES_MAX : i_fade_frames;
        fade_ok = i_func && i_player_open && i_has_audio;
        active  = !i_func && i_player_open && i_playing && i_has_audio && i_decoded_valid;

        tgt_fix = VOL_W'(tgt_cl) << VOLUME_FRAC_BITS;
        cur_fix = VOL_W'(r_target) << VOLUME_FRAC_BITS;
        num     = {tgt_fix[VOL_W-1], tgt_fix} - {r_cur[VOL_W-1], r_cur};
        num_mag = num[VOL_W] ? VOL_W'(-num) : num[VOL_W-1:0];

        vsum = {r_cur[VOL_W-1], r_cur} + {r_step[VOL_W-1], r_step};
        if (vsum > SUM_HI) begin
            vsat = SUM_HI[VOL_W-1:0];
        end else if (vsum < SUM_LO) begin
            vsat = SUM_LO[VOL_W-1:0];
        end else begin
            vsat = vsum[VOL_W-1:0];
        end
    end

    assign o_stat.need_div = fade_ok && (frm_cl != '0);
    assign o_stat.div_done = div_done;

    sfm_div #(
        .NUM_W (VOL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load && o_stat.need_div),
        .i_dividend (num_mag),
        .i_divisor  ({frm_cl, STEP_SHIFT'(0)}),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_step   <= '0;
            r_target <= '0;
            r_steps  <= '0;
        end else begin
            if (i_cmd.load && active) begin
                if (r_steps != '0) begin
                    r_steps <= r_steps - 1'b1;
                    r_cur   <= vsat;
                end else begin
                    r_cur <= cur_fix;
                end
            end
            if (i_cmd.load && fade_ok) begin
                r_target <= tgt_cl;
                r_steps  <= {frm_cl, STEP_SHIFT'(0)};
                if (frm_cl == '0) begin
                    r_cur <= tgt_fix;
                end
            end
            if (div_done) begin
                r_step <= r_neg ? -$signed(div_quot) : $signed(div_quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_act    <= active;
            r_acc    <= fade_ok;
            r_neg    <= num[VOL_W];
            r_base_l <= i_have_source ? i_src_left : '0;
            r_base_r <= i_have_source ? i_src_right : '0;
            r_dec_l  <= i_decoded_left;
            r_dec_r  <= i_decoded_right;
        end
    end

    // Mixing uses the volume already advanced at the load edge.
    always_comb begin
        ipart = r_cur[VOL_W-1:VOLUME_FRAC_BITS];
        if (ipart < 0) begin
            idx = '0;
        end else if (ipart > $signed((VOL_W - VOLUME_FRAC_BITS)'(LEVEL_MAX))) begin
            idx = LEVEL_MAX;
        end else begin
            idx = ipart[LEVEL_W-1:0];
        end
        gain   = sfm_gain(idx);
        prod_l = $signed({1'b0, gain}) * r_dec_l;
        prod_r = $signed({1'b0, gain}) * r_dec_r;
        mix_l  = MIX_W'(r_base_l) + MIX_W'($signed(prod_l[PROD_W-1:GAIN_SHIFT]));
        mix_r  = MIX_W'(r_base_r) + MIX_W'($signed(prod_r[PROD_W-1:GAIN_SHIFT]));
        sat_l  = sat16(mix_l);
        sat_r  = sat16(mix_r);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            o_fade_accepted   <= r_acc;
            o_sample_consumed <= r_act;
            if (r_func) begin
                o_out_left  <= '0;
                o_out_right <= '0;
            end else if (r_act) begin
                o_out_left  <= sat_l;
                o_out_right <= sat_r;
            end else begin
                o_out_left  <= r_base_l;
                o_out_right <= r_base_r;
            end
        end
    end

endmodule

[sv/sfm_ctrl.sv]
`timescale 1ns / 1ps

module sfm_ctrl import sfm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.out_write = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.need_div ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait here while the previous result is still held downstream.
                if (!r_valid || !i_stall) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_valid = o_cmd.out_write || (r_valid && i_stall);
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

[sv/stereo_fade_mixer.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_func .. i_fade_frames
// output   out        o_valid / i_stall  o_out_left .. o_fade_accepted
//
// A sample beat or a fade without divide is loaded, then mixed into the output register.
// A fade with nonzero length also waits for the bit-serial step divider.
// The next beat is taken as soon as the result is registered, even if it is not yet read.
// i_rst_n is synchronous and clears the volume ramp state and both handshakes.
// A stalled result holds in the output register; a new result waits for it to drain.
module stereo_fade_mixer import sfm_pkg::*; #(
    parameter int VOLUME_FRAC_BITS = VOLUME_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_func,
    input  logic                       i_player_open,
    input  logic                       i_has_audio,
    input  logic                       i_playing,
    input  logic                       i_have_source,
    input  logic signed [SAMPLE_W-1:0] i_src_left,
    input  logic signed [SAMPLE_W-1:0] i_src_right,
    input  logic                       i_decoded_valid,
    input  logic signed [SAMPLE_W-1:0] i_decoded_left,
    input  logic signed [SAMPLE_W-1:0] i_decoded_right,
    input  logic signed [SAMPLE_W-1:0] i_fade_volume,
    input  logic [FRAMES_W-1:0]        i_fade_frames,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_out_left,
    output logic signed [SAMPLE_W-1:0] o_out_right,
    output logic                       o_sample_consumed,
    output logic                       o_fade_accepted
);

    t_cmd  cmd;
    t_stat stat;

    sfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    sfm_dp #(
        .VOLUME_FRAC_BITS (VOLUME_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_func            (i_func),
        .i_player_open     (i_player_open),
        .i_has_audio       (i_has_audio),
        .i_playing         (i_playing),
        .i_have_source     (i_have_source),
        .i_src_left        (i_src_left),
        .i_src_right       (i_src_right),
        .i_decoded_valid   (i_decoded_valid),
        .i_decoded_left    (i_decoded_left),
        .i_decoded_right   (i_decoded_right),
        .i_fade_volume     (i_fade_volume),
        .i_fade_frames     (i_fade_frames),
        .o_out_left        (o_out_left),
        .o_out_right       (o_out_right),
        .o_sample_consumed (o_sample_consumed),
        .o_fade_accepted   (o_fade_accepted)
    );

endmodule

[sv/sfm_checker.sv]
`timescale 1ns / 1ps

module sfm_checker import sfm_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [SAMPLE_W-1:0] o_out_left,
    input logic signed [SAMPLE_W-1:0] o_out_right,
    input logic                       o_sample_consumed,
    input logic                       o_fade_accepted
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_left) && $stable(o_out_right)
            && $stable(o_sample_consumed) && $stable(o_fade_accepted))
        else $error("output beat changed while stalled");

    // The block works on one beat at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after a beat was accepted");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_sample_consumed && o_fade_accepted))
        else $error("sample and fade flags both set");

    // A fade result carries silence on both channels.
    a_fade_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fade_accepted |-> o_out_left == 0 && o_out_right == 0)
        else $error("fade result carries sample data");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("handshake not cleared by reset");

endmodule

bind stereo_fade_mixer sfm_checker u_sfm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_out_left        (o_out_left),
    .o_out_right       (o_out_right),
    .o_sample_consumed (o_sample_consumed),
    .o_fade_accepted   (o_fade_accepted)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import sfm_pkg::*;

    localparam int  FRAC      = VOLUME_FRAC_BITS_DEF;
    localparam logic FN_SAMPLE = 1'b0;
    localparam logic FN_FADE   = 1'b1;
    localparam int  HOLD_CYCLES = 300;

    typedef struct {
        logic                       func;
        logic                       player_open;
        logic                       has_audio;
        logic                       playing;
        logic                       have_source;
        logic signed [SAMPLE_W-1:0] src_left;
        logic signed [SAMPLE_W-1:0] src_right;
        logic                       decoded_valid;
        logic signed [SAMPLE_W-1:0] decoded_left;
        logic signed [SAMPLE_W-1:0] decoded_right;
        logic signed [SAMPLE_W-1:0] fade_volume;
        logic [FRAMES_W-1:0]        fade_frames;
    } t_mix_beat;

    typedef struct {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       sample_consumed;
        logic                       fade_accepted;
    } t_mix_out;

    class mix_scoreboard;
        longint      vol_q;
        longint      ramp_inc;
        int unsigned goal_level;
        int unsigned ramp_left;
        t_mix_out    pending_outputs[$];
        int          errors;
        int          n_beats;
        int          n_mixed;
        int          n_fades;
        int          n_refused;

        function new();
            vol_q = 0;
            ramp_inc = 0;
            goal_level = 0;
            ramp_left = 0;
            errors = 0;
            n_beats = 0;
            n_mixed = 0;
            n_fades = 0;
            n_refused = 0;
        endfunction

        function logic signed [SAMPLE_W-1:0] clip16(input int v);
            if (v < int'(S16_LO)) return S16_LO;
            if (v > int'(S16_HI)) return S16_HI;
            return v[SAMPLE_W-1:0];
        endfunction

        // Floor of gain * s / 32768, which is an arithmetic shift of the product.
        function int apply_gain(input logic [GAIN_W-1:0] g, input logic signed [SAMPLE_W-1:0] s);
            longint p;
            p = longint'(g) * longint'(s);
            return int'(p >>> GAIN_SHIFT);
        endfunction

        function void take_beat(input t_mix_beat b);
            t_mix_out          e;
            int                vol_req;
            int unsigned       frames;
            int                base_l;
            int                base_r;
            longint            lim;
            longint            ip;
            logic [GAIN_W-1:0] g;
            e.out_left = '0;
            e.out_right = '0;
            e.sample_consumed = 1'b0;
            e.fade_accepted = 1'b0;
            n_beats++;
            if (b.func == FN_FADE) begin
                if (b.player_open && b.has_audio) begin
                    vol_req = int'(b.fade_volume);
                    if (vol_req > int'(LEVEL_MAX)) vol_req = int'(LEVEL_MAX);
                    if (vol_req < 0) vol_req = 0;
                    frames = 32'(b.fade_frames);
                    if (frames > 32'(FADE_FRAMES_MAX)) frames = 32'(FADE_FRAMES_MAX);
                    goal_level = vol_req;
                    if (frames != 0) begin
                        ramp_left = frames << STEP_SHIFT;
                        ramp_inc = ((longint'(goal_level) << FRAC) - vol_q) / longint'(ramp_left);
                    end else begin
                        ramp_left = 0;
                        vol_q = longint'(goal_level) << FRAC;
                    end
                    e.fade_accepted = 1'b1;
                    n_fades++;
                end else begin
                    n_refused++;
                end
            end else begin
                base_l = b.have_source ? int'(b.src_left) : 0;
                base_r = b.have_source ? int'(b.src_right) : 0;
                if (b.player_open && b.playing && b.has_audio && b.decoded_valid) begin
                    lim = longint'(1) << (FRAC + 8);
                    if (ramp_left != 0) begin
                        ramp_left--;
                        vol_q += ramp_inc;
                        if (vol_q > lim) vol_q = lim;
                        if (vol_q < -lim) vol_q = -lim;
                    end else begin
                        vol_q = longint'(goal_level) << FRAC;
                    end
                    ip = (vol_q >= 0) ? (vol_q >>> FRAC) : -1;
                    if (ip > longint'(LEVEL_MAX)) ip = longint'(LEVEL_MAX);
                    if (ip < 0) ip = 0;
                    g = GAIN_CURVE[ip[LEVEL_W-1:0]];
                    e.out_left = clip16(base_l + apply_gain(g, b.decoded_left));
                    e.out_right = clip16(base_r + apply_gain(g, b.decoded_right));
                    e.sample_consumed = 1'b1;
                    n_mixed++;
                end else begin
                    e.out_left = base_l[SAMPLE_W-1:0];
                    e.out_right = base_r[SAMPLE_W-1:0];
                end
            end
            pending_outputs.push_back(e);
        endfunction

        function void check_out_beat(input t_mix_out got);
            t_mix_out want;
            if (pending_outputs.size() == 0) begin
                errors++;
                $error("output beat with nothing pending");
                return;
            end
            want = pending_outputs.pop_front();
            if (got.out_left !== want.out_left) begin
                errors++;
                $error("out_left: expected %0d, actual %0d", want.out_left, got.out_left);
            end
            if (got.out_right !== want.out_right) begin
                errors++;
                $error("out_right: expected %0d, actual %0d", want.out_right, got.out_right);
            end
            if (got.sample_consumed !== want.sample_consumed) begin
                errors++;
                $error("sample_consumed: expected %0b, actual %0b",
                       want.sample_consumed, got.sample_consumed);
            end
            if (got.fade_accepted !== want.fade_accepted) begin
                errors++;
                $error("fade_accepted: expected %0b, actual %0b",
                       want.fade_accepted, got.fade_accepted);
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_func;
    logic                       i_player_open;
    logic                       i_has_audio;
    logic                       i_playing;
    logic                       i_have_source;
    logic signed [SAMPLE_W-1:0] i_src_left;
    logic signed [SAMPLE_W-1:0] i_src_right;
    logic                       i_decoded_valid;
    logic signed [SAMPLE_W-1:0] i_decoded_left;
    logic signed [SAMPLE_W-1:0] i_decoded_right;
    logic signed [SAMPLE_W-1:0] i_fade_volume;
    logic [FRAMES_W-1:0]        i_fade_frames;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_out_left;
    logic signed [SAMPLE_W-1:0] o_out_right;
    logic                       o_sample_consumed;
    logic                       o_fade_accepted;

    mix_scoreboard sb;
    t_mix_beat     seen_in;
    t_mix_out      seen_out;
    bit            tx_idle;
    bit            rx_idle;
    bit            hold_req;

    stereo_fade_mixer #(
        .VOLUME_FRAC_BITS(FRAC)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_player_open    (i_player_open),
        .i_has_audio      (i_has_audio),
        .i_playing        (i_playing),
        .i_have_source    (i_have_source),
        .i_src_left       (i_src_left),
        .i_src_right      (i_src_right),
        .i_decoded_valid  (i_decoded_valid),
        .i_decoded_left   (i_decoded_left),
        .i_decoded_right  (i_decoded_right),
        .i_fade_volume    (i_fade_volume),
        .i_fade_frames    (i_fade_frames),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_left       (o_out_left),
        .o_out_right      (o_out_right),
        .o_sample_consumed(o_sample_consumed),
        .o_fade_accepted  (o_fade_accepted)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Both channels are observed at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                seen_in.func = i_func;
                seen_in.player_open = i_player_open;
                seen_in.has_audio = i_has_audio;
                seen_in.playing = i_playing;
                seen_in.have_source = i_have_source;
                seen_in.src_left = i_src_left;
                seen_in.src_right = i_src_right;
                seen_in.decoded_valid = i_decoded_valid;
                seen_in.decoded_left = i_decoded_left;
                seen_in.decoded_right = i_decoded_right;
                seen_in.fade_volume = i_fade_volume;
                seen_in.fade_frames = i_fade_frames;
                sb.take_beat(seen_in);
            end
            if (o_valid && !i_stall) begin
                seen_out.out_left = o_out_left;
                seen_out.out_right = o_out_right;
                seen_out.sample_consumed = o_sample_consumed;
                seen_out.fade_accepted = o_fade_accepted;
                sb.check_out_beat(seen_out);
            end
        end
    end

    // Output side: random stall bursts, or one long hold-off on request.
    initial begin : rx_side
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                i_stall = 1'b0;
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_mix_beat make_beat(
        input logic func, input logic open, input logic audio, input logic play,
        input logic have_src, input logic signed [SAMPLE_W-1:0] sl,
        input logic signed [SAMPLE_W-1:0] sr, input logic dv,
        input logic signed [SAMPLE_W-1:0] dl, input logic signed [SAMPLE_W-1:0] dr,
        input logic signed [SAMPLE_W-1:0] fv, input logic [FRAMES_W-1:0] ff);
        t_mix_beat b;
        b.func = func;
        b.player_open = open;
        b.has_audio = audio;
        b.playing = play;
        b.have_source = have_src;
        b.src_left = sl;
        b.src_right = sr;
        b.decoded_valid = dv;
        b.decoded_left = dl;
        b.decoded_right = dr;
        b.fade_volume = fv;
        b.fade_frames = ff;
        return b;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S16_HI;
            1: return S16_LO;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly beats from an open, playing player, so the ramp actually moves.
    function automatic t_mix_beat rand_beat(input int fade_odds);
        t_mix_beat b;
        bit        tidy;
        tidy = ($urandom_range(0, 9) != 0);
        b.func = ($urandom_range(1, fade_odds) == 1) ? FN_FADE : FN_SAMPLE;
        if (tidy) begin
            b.player_open = 1'b1;
            b.has_audio = 1'b1;
            b.playing = 1'b1;
            b.decoded_valid = ($urandom_range(0, 15) != 0);
        end else begin
            b.player_open = 1'($urandom_range(0, 1));
            b.has_audio = 1'($urandom_range(0, 1));
            b.playing = 1'($urandom_range(0, 1));
            b.decoded_valid = 1'($urandom_range(0, 1));
        end
        b.have_source = 1'($urandom_range(0, 1));
        b.src_left = pick_sample();
        b.src_right = pick_sample();
        b.decoded_left = pick_sample();
        b.decoded_right = pick_sample();
        if ($urandom_range(0, 3) == 0) b.fade_volume = SAMPLE_W'($urandom);
        else b.fade_volume = SAMPLE_W'($urandom_range(0, 127));
        case ($urandom_range(0, 7))
            0: b.fade_frames = '0;
            1: b.fade_frames = FRAMES_W'($urandom);
            default: b.fade_frames = FRAMES_W'($urandom_range(1, 2));
        endcase
        return b;
    endfunction

    // Starts and ends on a falling edge; valid stays high until the beat is taken.
    task automatic send_beat(input t_mix_beat b);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_func = b.func;
        i_player_open = b.player_open;
        i_has_audio = b.has_audio;
        i_playing = b.playing;
        i_have_source = b.have_source;
        i_src_left = b.src_left;
        i_src_right = b.src_right;
        i_decoded_valid = b.decoded_valid;
        i_decoded_left = b.decoded_left;
        i_decoded_right = b.decoded_right;
        i_fade_volume = b.fade_volume;
        i_fade_frames = b.fade_frames;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_outputs();
        i_valid = 1'b0;
        while (sb.pending_outputs.size() != 0) @(negedge i_clk);
    endtask

    initial begin : main_seq
        int k;
        sb = new();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FN_SAMPLE;
        i_player_open = 1'b0;
        i_has_audio = 1'b0;
        i_playing = 1'b0;
        i_have_source = 1'b0;
        i_src_left = '0;
        i_src_right = '0;
        i_decoded_valid = 1'b0;
        i_decoded_left = '0;
        i_decoded_right = '0;
        i_fade_volume = '0;
        i_fade_frames = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Volume is zero out of reset, so the mix is just the source.
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd1234, -16'sd77, 1'b1,
                            S16_HI, S16_LO, 16'sd0, 16'd0));
        // Refused fades: closed player, no audio track, neither.
        send_beat(make_beat(FN_FADE, 1'b0, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, 16'sd100, 16'd0));
        send_beat(make_beat(FN_FADE, 1'b1, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, 16'sd100, 16'd0));
        send_beat(make_beat(FN_FADE, 1'b0, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, 16'sd100, 16'd3));
        // Zero-length fade jumps to full volume.
        send_beat(make_beat(FN_FADE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, 16'sd127, 16'd0));
        // Saturation at both rails.
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, S16_HI, S16_LO, 1'b1,
                            S16_HI, S16_LO, 16'sd0, 16'd0));
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0, S16_HI, S16_HI, 1'b1,
                            S16_LO, S16_HI, 16'sd0, 16'd0));
        // Inactive cases pass the source through and hold the ramp.
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b1, 16'sd500, -16'sd500, 1'b1,
                            S16_HI, S16_HI, 16'sd0, 16'd0));
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, -16'sd9, 16'sd9, 1'b0,
                            S16_HI, S16_HI, 16'sd0, 16'd0));
        send_beat(make_beat(FN_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b1, S16_LO, S16_HI, 1'b1,
                            S16_HI, S16_HI, 16'sd0, 16'd0));
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0, S16_LO, S16_HI, 1'b1,
                            S16_HI, S16_HI, 16'sd0, 16'd0));
        // Target and length above their limits are clamped.
        send_beat(make_beat(FN_FADE, 1'b1, 1'b1, 1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0,
                            16'sd0, 16'sd0, S16_HI, 16'hffff));
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd3, 16'sd4, 1'b1,
                            16'sd20000, -16'sd20000, 16'sd0, 16'd0));
        // Negative target clamps to zero; a one-frame ramp down.
        send_beat(make_beat(FN_FADE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, S16_LO, 16'd1));
        for (k = 0; k < 4; k++) begin
            send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                                S16_HI, S16_LO, 16'sd0, 16'd0));
        end
        // A jump in the middle of a ramp ends it.
        send_beat(make_beat(FN_FADE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, 16'sd64, 16'd0));
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, -16'sd1, 16'sd1, 1'b1,
                            16'sd12345, -16'sd12345, 16'sd0, 16'd0));
        send_beat(make_beat(FN_FADE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd0, 16'sd0, 16'sd200, 16'd2));
        send_beat(make_beat(FN_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1,
                            16'sd7, -16'sd7, 16'sd0, 16'd0));

        for (k = 0; k < 300; k++) send_beat(rand_beat(12));

        // Hold the output side off while beats keep coming, so the block backs up.
        tx_idle = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 30; k++) send_beat(rand_beat(6));
        tx_idle = 1'b1;
        drain_outputs();

        // Rare fades here, so ramps run to completion and settle on the target.
        for (k = 0; k < 200; k++) send_beat(rand_beat(48));

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (k = 0; k < 120; k++) send_beat(rand_beat(16));

        drain_outputs();
        repeat (60) @(negedge i_clk);

        $display("Ran %0d beats: %0d mixed samples, %0d fades taken, %0d fades refused.",
                 sb.n_beats, sb.n_mixed, sb.n_fades, sb.n_refused);
        $display("Stimulus covered clamping, saturation, inactive pass-through and back-pressure.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
